/* rtl/skt_pkg.sv */
package skt_pkg;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_DUP      = 3'd1;
  localparam logic [2:0] ST_NOTFOUND = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_RANGE    = 3'd4;

  typedef struct packed {
    logic [31:0]      key;
    logic [31:0]      value;
    logic [3:0][31:0] handle;
    logic [1:0]       interp;
  } entry_t;

  typedef enum logic [1:0] {
    RD_IDX,
    RD_PREV,
    RD_NEXT,
    RD_INDEX
  } rd_sel_e;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_CLR,
    IDX_INC,
    IDX_DEC,
    IDX_LD_CNT
  } idx_op_e;

  typedef struct packed {
    logic       capture;
    logic       rd_en;
    rd_sel_e    rd_sel;
    logic       wr_en;
    logic       wr_new;
    idx_op_e    idx_op;
    logic       pos_ld;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       st_ld;
    logic [2:0] st_code;
    logic       read_hit;
    logic       out_ld;
  } ctrl_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       idx_eq_cnt;
    logic       idx_eq_pos;
    logic       next_eq_cnt;
    logic       key_eq;
    logic       key_lt;
    logic       full;
    logic       range_err;
  } stat_t;

endpackage

/* rtl/sorted_keyframe_table.sv */
// A read or an unknown command goes from the dispatch state straight to the done state, where its result is registered.
// Insert and remove scan from the lowest entry, one compared entry at a time, through the
// single read port, then move each shifted entry by a read and then a write back.
// One item is in work at a time; the next transfer is taken once the result is registered.
// Reset clears the entry count and the control state; entry storage is not cleared.
module sorted_keyframe_table #(
  parameter int DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         cmd_i,
  input  logic signed [31:0] key_i,
  input  logic [31:0]        value_i,
  input  logic [31:0]        handle_0_i,
  input  logic [31:0]        handle_1_i,
  input  logic [31:0]        handle_2_i,
  input  logic [31:0]        handle_3_i,
  input  logic [1:0]         interp_mode_i,
  input  logic [5:0]         read_index_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         status_o,
  output logic [6:0]         entry_count_o,
  output logic signed [31:0] out_key_o,
  output logic [31:0]        out_value_o,
  output logic [31:0]        out_handle_0_o,
  output logic [31:0]        out_handle_1_o,
  output logic [31:0]        out_handle_2_o,
  output logic [31:0]        out_handle_3_o,
  output logic [1:0]         out_interp_mode_o
);

  skt_pkg::ctrl_t  ctrl;
  skt_pkg::stat_t  stat;
  skt_pkg::entry_t entry_in;
  skt_pkg::entry_t entry_out;

  always_comb begin
    entry_in.key       = key_i;
    entry_in.value     = value_i;
    entry_in.handle[0] = handle_0_i;
    entry_in.handle[1] = handle_1_i;
    entry_in.handle[2] = handle_2_i;
    entry_in.handle[3] = handle_3_i;
    entry_in.interp    = interp_mode_i;
  end

  skt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  skt_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .stat_o        (stat),
    .cmd_i         (cmd_i),
    .entry_i       (entry_in),
    .read_index_i  (read_index_i),
    .status_o      (status_o),
    .entry_count_o (entry_count_o),
    .entry_o       (entry_out)
  );

  assign out_key_o         = $signed(entry_out.key);
  assign out_value_o       = entry_out.value;
  assign out_handle_0_o    = entry_out.handle[0];
  assign out_handle_1_o    = entry_out.handle[1];
  assign out_handle_2_o    = entry_out.handle[2];
  assign out_handle_3_o    = entry_out.handle[3];
  assign out_interp_mode_o = entry_out.interp;

endmodule

/* rtl/skt_ctrl.sv */
module skt_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  skt_pkg::stat_t stat_i,
  output skt_pkg::ctrl_t ctrl_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DISP = 4'd1;
  localparam logic [3:0] S_SRD  = 4'd2;
  localparam logic [3:0] S_SCMP = 4'd3;
  localparam logic [3:0] S_IRD  = 4'd4;
  localparam logic [3:0] S_IWR  = 4'd5;
  localparam logic [3:0] S_RRD  = 4'd6;
  localparam logic [3:0] S_RWR  = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    ctrl_o = '0;
    ctrl_o.rd_sel = skt_pkg::RD_IDX;
    ctrl_o.idx_op = skt_pkg::IDX_HOLD;
    ctrl_o.st_code = skt_pkg::ST_OK;
    state_d = state_q;
    out_valid_d = out_valid_q && !out_ready_i;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.capture = 1'b1;
          ctrl_o.idx_op  = skt_pkg::IDX_CLR;
          state_d        = S_DISP;
        end
      end
      S_DISP: begin
        ctrl_o.st_ld = 1'b1;
        if (stat_i.cmd == skt_pkg::CMD_INSERT || stat_i.cmd == skt_pkg::CMD_REMOVE) begin
          ctrl_o.st_ld = 1'b0;
          state_d      = S_SRD;
        end else if (stat_i.cmd == skt_pkg::CMD_READ) begin
          if (stat_i.range_err) begin
            ctrl_o.st_code = skt_pkg::ST_RANGE;
          end else begin
            ctrl_o.rd_en    = 1'b1;
            ctrl_o.rd_sel   = skt_pkg::RD_INDEX;
            ctrl_o.read_hit = 1'b1;
          end
          state_d = S_DONE;
        end else begin
          state_d = S_DONE;
        end
      end
      S_SRD: begin
        if (stat_i.idx_eq_cnt) begin
          if (stat_i.cmd == skt_pkg::CMD_INSERT) begin
            if (stat_i.full) begin
              ctrl_o.st_ld   = 1'b1;
              ctrl_o.st_code = skt_pkg::ST_FULL;
              state_d        = S_DONE;
            end else begin
              ctrl_o.pos_ld = 1'b1;
              ctrl_o.idx_op = skt_pkg::IDX_LD_CNT;
              state_d       = S_IRD;
            end
          end else begin
            ctrl_o.st_ld   = 1'b1;
            ctrl_o.st_code = skt_pkg::ST_NOTFOUND;
            state_d        = S_DONE;
          end
        end else begin
          ctrl_o.rd_en  = 1'b1;
          ctrl_o.rd_sel = skt_pkg::RD_IDX;
          state_d       = S_SCMP;
        end
      end
      S_SCMP: begin
        if (stat_i.key_eq) begin
          if (stat_i.cmd == skt_pkg::CMD_INSERT) begin
            ctrl_o.st_ld   = 1'b1;
            ctrl_o.st_code = skt_pkg::ST_DUP;
            state_d        = S_DONE;
          end else begin
            state_d = S_RRD;
          end
        end else if (stat_i.key_lt) begin
          if (stat_i.cmd == skt_pkg::CMD_INSERT) begin
            if (stat_i.full) begin
              ctrl_o.st_ld   = 1'b1;
              ctrl_o.st_code = skt_pkg::ST_FULL;
              state_d        = S_DONE;
            end else begin
              ctrl_o.pos_ld = 1'b1;
              ctrl_o.idx_op = skt_pkg::IDX_LD_CNT;
              state_d       = S_IRD;
            end
          end else begin
            ctrl_o.st_ld   = 1'b1;
            ctrl_o.st_code = skt_pkg::ST_NOTFOUND;
            state_d        = S_DONE;
          end
        end else begin
          ctrl_o.idx_op = skt_pkg::IDX_INC;
          state_d       = S_SRD;
        end
      end
      S_IRD: begin
        if (stat_i.idx_eq_pos) begin
          ctrl_o.wr_en   = 1'b1;
          ctrl_o.wr_new  = 1'b1;
          ctrl_o.cnt_inc = 1'b1;
          ctrl_o.st_ld   = 1'b1;
          state_d        = S_DONE;
        end else begin
          ctrl_o.rd_en  = 1'b1;
          ctrl_o.rd_sel = skt_pkg::RD_PREV;
          state_d       = S_IWR;
        end
      end
      S_IWR: begin
        ctrl_o.wr_en  = 1'b1;
        ctrl_o.idx_op = skt_pkg::IDX_DEC;
        state_d       = S_IRD;
      end
      S_RRD: begin
        if (stat_i.next_eq_cnt) begin
          ctrl_o.cnt_dec = 1'b1;
          ctrl_o.st_ld   = 1'b1;
          state_d        = S_DONE;
        end else begin
          ctrl_o.rd_en  = 1'b1;
          ctrl_o.rd_sel = skt_pkg::RD_NEXT;
          state_d       = S_RWR;
        end
      end
      S_RWR: begin
        ctrl_o.wr_en  = 1'b1;
        ctrl_o.idx_op = skt_pkg::IDX_INC;
        state_d       = S_RRD;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          ctrl_o.out_ld = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/skt_datapath.sv */
module skt_datapath #(
  parameter int DEPTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  skt_pkg::ctrl_t      ctrl_i,
  output skt_pkg::stat_t      stat_o,
  input  logic [1:0]          cmd_i,
  input  skt_pkg::entry_t     entry_i,
  input  logic [5:0]          read_index_i,
  output logic [2:0]          status_o,
  output logic [6:0]          entry_count_o,
  output skt_pkg::entry_t     entry_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  skt_pkg::entry_t mem [DEPTH];
  skt_pkg::entry_t rdata_q;
  skt_pkg::entry_t item_q;
  skt_pkg::entry_t wdata;
  skt_pkg::entry_t out_entry_q;

  logic [1:0]    cmd_q;
  logic [5:0]    read_index_q;
  logic [CW-1:0] idx_q, idx_d, pos_q, cnt_q, cnt_d;
  logic [CW-1:0] idx_prev, idx_next;
  logic [CW+5:0] rd_idx_ext, cnt_ext;
  logic [CW+6:0] cnt_wide;
  logic [AW-1:0] rd_addr;
  logic [2:0]    st_q;
  logic          read_hit_q;
  logic [2:0]    out_status_q;
  logic [6:0]    out_count_q;

  assign idx_prev   = idx_q - CW'(1);
  assign idx_next   = idx_q + CW'(1);
  assign rd_idx_ext = {{CW{1'b0}}, read_index_q};
  assign cnt_ext    = {6'b0, cnt_q};
  assign cnt_wide   = {7'b0, cnt_q};

  always_comb begin
    unique case (ctrl_i.rd_sel)
      skt_pkg::RD_IDX:   rd_addr = idx_q[AW-1:0];
      skt_pkg::RD_PREV:  rd_addr = idx_prev[AW-1:0];
      skt_pkg::RD_NEXT:  rd_addr = idx_next[AW-1:0];
      skt_pkg::RD_INDEX: rd_addr = rd_idx_ext[AW-1:0];
      default:           rd_addr = idx_q[AW-1:0];
    endcase
  end

  assign wdata = ctrl_i.wr_new ? item_q : rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem[idx_q[AW-1:0]] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      item_q       <= entry_i;
      cmd_q        <= cmd_i;
      read_index_q <= read_index_i;
    end
    if (ctrl_i.pos_ld) begin
      pos_q <= idx_q;
    end
    if (ctrl_i.st_ld) begin
      st_q       <= ctrl_i.st_code;
      read_hit_q <= ctrl_i.read_hit;
    end
    if (ctrl_i.out_ld) begin
      out_status_q <= st_q;
      out_count_q  <= cnt_wide[6:0];
      out_entry_q  <= read_hit_q ? rdata_q : '0;
    end
  end

  always_comb begin
    case (ctrl_i.idx_op)
      skt_pkg::IDX_CLR:    idx_d = '0;
      skt_pkg::IDX_INC:    idx_d = idx_next;
      skt_pkg::IDX_DEC:    idx_d = idx_prev;
      skt_pkg::IDX_LD_CNT: idx_d = cnt_q;
      default:             idx_d = idx_q;
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    if (ctrl_i.cnt_inc) begin
      cnt_d = cnt_q + CW'(1);
    end else if (ctrl_i.cnt_dec) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      cnt_q <= '0;
    end else begin
      idx_q <= idx_d;
      cnt_q <= cnt_d;
    end
  end

  always_comb begin
    stat_o.cmd         = cmd_q;
    stat_o.idx_eq_cnt  = (idx_q == cnt_q);
    stat_o.idx_eq_pos  = (idx_q == pos_q);
    stat_o.next_eq_cnt = (({1'b0, idx_q} + (CW + 1)'(1)) == {1'b0, cnt_q});
    stat_o.key_eq      = (rdata_q.key == item_q.key);
    stat_o.key_lt      = ($signed(item_q.key) < $signed(rdata_q.key));
    stat_o.full        = (cnt_q == CW'(DEPTH));
    stat_o.range_err   = (rd_idx_ext >= cnt_ext);
  end

  assign status_o      = out_status_q;
  assign entry_count_o = out_count_q;
  assign entry_o       = out_entry_q;

endmodule
